// ===== rtl/lpq_pkg.sv =====
package lpq_pkg;

    localparam int LEN_W     = 13;
    localparam int BYTE_W    = 8;
    localparam int STAT_W    = 3;
    localparam int HDR_BYTES = 4;
    localparam int HDR_W     = 8 * HDR_BYTES;
    localparam int CNT_W     = 3;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_REJECT  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_BAD_LEN = 3'd3,
        ST_BAD_ARG = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    wr_in;       // store the input byte at the write position
        logic    push_cont;   // count down a push in progress
        logic    start_drop;  // begin dropping a rejected record
        logic    latch;       // capture the item fields, clear the step counter
        logic    wr_hdr;      // write one header byte or the first payload byte
        logic    push_done;   // header written, load the remaining push count
        logic    scan_load;   // header scan starts at the read position
        logic    hdr_step;    // one step of the header read
        logic    hdr_commit;  // header accepted, consume it
        logic    rd_scan;     // read address from the scan pointer
        logic    take;        // consume one payload byte
        logic    out_load;    // load the result register
        status_t res_status;
        logic    res_bvalid;
        logic    res_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic push_busy;
        logic push_drop;
        logic push_rem_one;
        logic pop_busy;
        logic pop_rem_one;
        logic len_zero;
        logic len_one;
        logic len_l_one;
        logic max_zero;
        logic no_fit;
        logic hdr_short;
        logic chk_bad;
        logic stored_zero;
        logic cnt_end;
    } dp_flag_t;

endpackage

// ===== rtl/lpq_in_if.sv =====
interface lpq_in_if;
    import lpq_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [LEN_W-1:0] push_len;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0] max_len;

    modport source (output valid, output cmd, output push_len, output data, output max_len,
                    input ready);
    modport sink (input valid, input cmd, input push_len, input data, input max_len,
                  output ready);
endinterface

// ===== rtl/lpq_out_if.sv =====
interface lpq_out_if;
    import lpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;

    modport source (output valid, output status, output out_byte, output byte_valid,
                    output last, input ready);
    modport sink (input valid, input status, input out_byte, input byte_valid,
                  input last, output ready);
endinterface

// ===== rtl/lpq_ram.sv =====
module lpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/lpq_datapath.sv =====
module lpq_datapath #(
    parameter int RING_BYTES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lpq_pkg::dp_cmd_t           cmd,
    output lpq_pkg::dp_flag_t          flag,
    input  logic [lpq_pkg::LEN_W-1:0]  in_push_len,
    input  logic [lpq_pkg::BYTE_W-1:0] in_data,
    input  logic [lpq_pkg::LEN_W-1:0]  in_max_len,
    input  logic                       cfg_we,
    input  logic [lpq_pkg::LEN_W-1:0]  cfg_data,
    output logic [lpq_pkg::STAT_W-1:0] res_status,
    output logic [lpq_pkg::BYTE_W-1:0] res_byte,
    output logic                       res_bvalid,
    output logic                       res_last
);
    import lpq_pkg::*;

    localparam int AW    = $clog2(RING_BYTES);
    localparam int PW    = AW + 1;
    localparam int CMPW  = (PW > LEN_W) ? PW : LEN_W;
    localparam int SUMW  = CMPW + 2;
    localparam int SIZE_MIN = HDR_BYTES + 1;
    localparam logic [PW-1:0] SIZE_RESET = PW'((RING_BYTES < 4096) ? RING_BYTES : 4096);

    logic [PW-1:0]     ring_size_reg, ring_size_next;
    logic [AW-1:0]     write_pos_reg, write_pos_next;
    logic [AW-1:0]     read_pos_reg, read_pos_next;
    logic [AW-1:0]     scan_reg, scan_next;
    logic [PW-1:0]     used_reg, used_next;
    logic [LEN_W-1:0]  push_rem_reg, push_rem_next;
    logic              drop_reg, drop_next;
    logic [LEN_W-1:0]  pop_rem_reg, pop_rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [LEN_W-1:0]  len_l_reg, len_l_next;
    logic [BYTE_W-1:0] data_l_reg, data_l_next;
    logic [LEN_W-1:0]  max_l_reg, max_l_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    status_t           out_status_reg, out_status_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_bvalid_reg, out_bvalid_next;
    logic              out_last_reg, out_last_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] hdr_byte;
    logic [CMPW-1:0]   cfg_ext;
    logic [PW-1:0]     size_clamped;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                               input logic [PW-1:0] size);
        logic [PW-1:0] n;
        n = {1'b0, p} + PW'(1);
        return (n >= size) ? '0 : n[AW-1:0];
    endfunction

    lpq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_addr = cmd.rd_scan ? scan_reg : read_pos_reg;
    assign wr_addr = write_pos_reg;

    // Little-endian length header, then the first payload byte.
    always_comb
    begin
        case (cnt_reg)
            3'd0:    hdr_byte = len_l_reg[7:0];
            3'd1:    hdr_byte = BYTE_W'(len_l_reg[LEN_W-1:8]);
            3'd2:    hdr_byte = '0;
            3'd3:    hdr_byte = '0;
            default: hdr_byte = data_l_reg;
        endcase
    end

    always_comb
    begin
        cfg_ext = CMPW'(cfg_data);
        if (cfg_ext < CMPW'(SIZE_MIN))
        begin
            size_clamped = PW'(SIZE_MIN);
        end
        else if (cfg_ext > CMPW'(RING_BYTES))
        begin
            size_clamped = PW'(RING_BYTES);
        end
        else
        begin
            size_clamped = PW'(cfg_ext);
        end
    end

    always_comb
    begin
        flag.push_busy    = (push_rem_reg != '0);
        flag.push_drop    = drop_reg;
        flag.push_rem_one = (push_rem_reg == LEN_W'(1));
        flag.pop_busy     = (pop_rem_reg != '0);
        flag.pop_rem_one  = (pop_rem_reg == LEN_W'(1));
        flag.len_zero     = (in_push_len == '0);
        flag.len_one      = (in_push_len == LEN_W'(1));
        flag.len_l_one    = (len_l_reg == LEN_W'(1));
        flag.max_zero     = (in_max_len == '0);
        flag.no_fit       = (SUMW'(used_reg) + SUMW'(in_push_len) + SUMW'(HDR_BYTES))
                            > SUMW'(ring_size_reg);
        flag.hdr_short    = (used_reg < PW'(HDR_BYTES));
        flag.chk_bad      = (hdr_reg > HDR_W'(max_l_reg))
                            || ((33'(hdr_reg) + 33'(HDR_BYTES)) > 33'(used_reg));
        flag.stored_zero  = (hdr_reg == '0);
        flag.cnt_end      = (cnt_reg == CNT_W'(HDR_BYTES));
    end

    always_comb
    begin
        ring_size_next  = ring_size_reg;
        write_pos_next  = write_pos_reg;
        read_pos_next   = read_pos_reg;
        scan_next       = scan_reg;
        used_next       = used_reg;
        push_rem_next   = push_rem_reg;
        drop_next       = drop_reg;
        pop_rem_next    = pop_rem_reg;
        cnt_next        = cnt_reg;
        len_l_next      = len_l_reg;
        data_l_next     = data_l_reg;
        max_l_next      = max_l_reg;
        hdr_next        = hdr_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_data         = in_data;

        if (cmd.wr_in)
        begin
            wr_en          = 1'b1;
            wr_data        = in_data;
            write_pos_next = next_pos(write_pos_reg, ring_size_reg);
            used_next      = used_reg + PW'(1);
        end
        if (cmd.push_cont)
        begin
            push_rem_next = push_rem_reg - LEN_W'(1);
            if (push_rem_reg == LEN_W'(1))
            begin
                drop_next = 1'b0;
            end
        end
        if (cmd.start_drop)
        begin
            push_rem_next = in_push_len - LEN_W'(1);
            drop_next     = (in_push_len != LEN_W'(1));
        end
        if (cmd.latch)
        begin
            len_l_next  = in_push_len;
            data_l_next = in_data;
            max_l_next  = in_max_len;
            cnt_next    = '0;
        end
        if (cmd.wr_hdr)
        begin
            wr_en          = 1'b1;
            wr_data        = hdr_byte;
            write_pos_next = next_pos(write_pos_reg, ring_size_reg);
            used_next      = used_reg + PW'(1);
            cnt_next       = cnt_reg + CNT_W'(1);
        end
        if (cmd.push_done)
        begin
            push_rem_next = len_l_reg - LEN_W'(1);
            drop_next     = 1'b0;
        end
        if (cmd.scan_load)
        begin
            scan_next = read_pos_reg;
        end
        // Read data is registered behind its address, so the first step only issues.
        if (cmd.hdr_step)
        begin
            if (cnt_reg != CNT_W'(HDR_BYTES))
            begin
                scan_next = next_pos(scan_reg, ring_size_reg);
            end
            if (cnt_reg != '0)
            begin
                hdr_next = {rd_data, hdr_reg[HDR_W-1:BYTE_W]};
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.hdr_commit)
        begin
            read_pos_next = scan_reg;
            used_next     = used_reg - PW'(HDR_BYTES);
            pop_rem_next  = hdr_reg[LEN_W-1:0];
        end
        if (cmd.take)
        begin
            read_pos_next = next_pos(read_pos_reg, ring_size_reg);
            if (used_reg != '0)
            begin
                used_next = used_reg - PW'(1);
            end
            pop_rem_next = pop_rem_reg - LEN_W'(1);
        end
        if (cmd.out_load)
        begin
            out_status_next = cmd.res_status;
            out_byte_next   = cmd.res_bvalid ? rd_data : '0;
            out_bvalid_next = cmd.res_bvalid;
            out_last_next   = cmd.res_last;
        end
        // A new ring size empties the queue.
        if (cfg_we)
        begin
            ring_size_next = size_clamped;
            write_pos_next = '0;
            read_pos_next  = '0;
            used_next      = '0;
            push_rem_next  = '0;
            drop_next      = 1'b0;
            pop_rem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= SIZE_RESET;
            write_pos_reg <= '0;
            read_pos_reg  <= '0;
            scan_reg      <= '0;
            used_reg      <= '0;
            push_rem_reg  <= '0;
            drop_reg      <= 1'b0;
            pop_rem_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            ring_size_reg <= ring_size_next;
            write_pos_reg <= write_pos_next;
            read_pos_reg  <= read_pos_next;
            scan_reg      <= scan_next;
            used_reg      <= used_next;
            push_rem_reg  <= push_rem_next;
            drop_reg      <= drop_next;
            pop_rem_reg   <= pop_rem_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_l_reg      <= len_l_next;
        data_l_reg     <= data_l_next;
        max_l_reg      <= max_l_next;
        hdr_reg        <= hdr_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_last_reg   <= out_last_next;
    end

    assign res_status = out_status_reg;
    assign res_byte   = out_byte_reg;
    assign res_bvalid = out_bvalid_reg;
    assign res_last   = out_last_reg;

endmodule

// ===== rtl/lpq_ctrl.sv =====
module lpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    input  lpq_pkg::dp_flag_t  flag,
    output lpq_pkg::dp_cmd_t   cmd
);
    import lpq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_PUSH_HDR  = 5'b00010,
        S_POP_HDR   = 5'b00100,
        S_POP_CHECK = 5'b01000,
        S_POP_BYTE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // An item is taken only when the result register is free or draining.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = ST_OK;
        state_next     = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_PUSH)
                    begin
                        if (flag.push_busy)
                        begin
                            cmd.wr_in      = !flag.push_drop;
                            cmd.push_cont  = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.res_status = flag.push_drop ? ST_REJECT : ST_OK;
                            cmd.res_last   = flag.push_rem_one;
                        end
                        else if (flag.len_zero)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.res_status = ST_BAD_ARG;
                        end
                        else if (flag.no_fit)
                        begin
                            cmd.start_drop = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.res_status = ST_REJECT;
                            cmd.res_last   = flag.len_one;
                        end
                        else
                        begin
                            cmd.latch  = 1'b1;
                            state_next = S_PUSH_HDR;
                        end
                    end
                    else
                    begin
                        if (flag.pop_busy)
                        begin
                            // The read of the head byte is already under way.
                            state_next = S_POP_BYTE;
                        end
                        else if (flag.max_zero)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.res_status = ST_BAD_ARG;
                        end
                        else if (flag.hdr_short)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.latch     = 1'b1;
                            cmd.scan_load = 1'b1;
                            state_next    = S_POP_HDR;
                        end
                    end
                end
            end

            S_PUSH_HDR:
            begin
                cmd.wr_hdr = 1'b1;
                if (flag.cnt_end)
                begin
                    cmd.push_done = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.res_last  = flag.len_l_one;
                    state_next    = S_IDLE;
                end
            end

            S_POP_HDR:
            begin
                cmd.rd_scan  = 1'b1;
                cmd.hdr_step = 1'b1;
                if (flag.cnt_end)
                begin
                    state_next = S_POP_CHECK;
                end
            end

            S_POP_CHECK:
            begin
                cmd.rd_scan = 1'b1;
                if (flag.chk_bad)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.res_status = ST_BAD_LEN;
                    state_next     = S_IDLE;
                end
                else if (flag.stored_zero)
                begin
                    cmd.hdr_commit = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.res_last   = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.hdr_commit = 1'b1;
                    state_next     = S_POP_BYTE;
                end
            end

            S_POP_BYTE:
            begin
                cmd.take       = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.res_bvalid = 1'b1;
                cmd.res_last   = flag.pop_rem_one;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/length_prefixed_byte_ring_queue_unit.sv =====
// Channel   Direction  Handshake     Payload
// in_ch     in         valid/ready   cmd, push_len, data, max_len
// out_ch    out        valid/ready   status, out_byte, byte_valid, last
// cfg       in         cfg_we        cfg_data (ring size in bytes)
//
// A byte that continues a push is settled as soon as it is taken, and one that continues a pop
// goes through a further byte-read state, since the byte store's read port is registered.
// The first byte of a stored record goes as 4 header bytes and the payload byte, one by one
// through the single write port. The first byte of a pop takes 4 header reads, a length
// check, then the payload read. A bad stored length or a zero-length record is settled at
// the length check. Other rejected items and errors are settled as soon as the item is taken.
// Reset clears all pointers and counts; the byte store itself is not cleared.
// A result waits in an output register; a new item is taken once it is gone or leaving.
module length_prefixed_byte_ring_queue_unit #(
    parameter int RING_BYTES = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lpq_in_if.sink                    in_ch,
    lpq_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [lpq_pkg::LEN_W-1:0] cfg_data
);
    import lpq_pkg::*;

    dp_cmd_t  cmd;
    dp_flag_t flag;

    lpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_cmd    (in_ch.cmd),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .flag      (flag),
        .cmd       (cmd)
    );

    lpq_datapath #(
        .RING_BYTES (RING_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .flag        (flag),
        .in_push_len (in_ch.push_len),
        .in_data     (in_ch.data),
        .in_max_len  (in_ch.max_len),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .res_status  (out_ch.status),
        .res_byte    (out_ch.out_byte),
        .res_bvalid  (out_ch.byte_valid),
        .res_last    (out_ch.last)
    );

endmodule

// ===== rtl/lpq_checker.sv =====
module lpq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [lpq_pkg::STAT_W-1:0] status,
    input logic [lpq_pkg::BYTE_W-1:0] out_byte,
    input logic                       byte_valid,
    input logic                       last
);
    import lpq_pkg::*;

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_byte)
            && $stable(byte_valid) && $stable(last))
        else $error("stalled result changed");

    // No new item while a finished result is stuck.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(in_valid && in_ready))
        else $error("item taken while result is stalled");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> status == ST_OK)
        else $error("popped byte with error status");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == '0)
        else $error("out_byte not zero without a popped byte");

    // Errors that end no record never mark the end of one.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_BAD_LEN || status == ST_BAD_ARG)
            |-> !last && !byte_valid)
        else $error("error result marks last or carries a byte");

endmodule

bind length_prefixed_byte_ring_queue_unit lpq_checker u_lpq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .out_byte   (out_ch.out_byte),
    .byte_valid (out_ch.byte_valid),
    .last       (out_ch.last)
);
